/* rtl/ipth_pkg.sv */
// Package: shared types, codes and constants of the hashed inverted page table.
package ipth_pkg;

    localparam int NUM_FRAMES_DEF = 64;
    localparam int MAX_PAGES      = 64;
    localparam int FS_W           = 17;
    localparam int FIU_W          = 7;
    localparam int RES_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int PID_W          = 16;
    localparam int PAGE_W         = 12;
    localparam int OFS_W          = 16;
    localparam int CNT_W          = 7;
    localparam int FRAME_W        = 6;
    localparam int ADDR_W         = 24;

    localparam logic [1:0] FUNC_LOOKUP    = 2'd0;
    localparam logic [1:0] FUNC_ALLOC     = 2'd1;
    localparam logic [1:0] FUNC_REL_PID   = 2'd2;
    localparam logic [1:0] FUNC_REL_PAGE  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_NOFREE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] page;
        logic [OFS_W-1:0]  offset;
        logic [CNT_W-1:0]  page_count;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  result_page;
        logic [ADDR_W-1:0]  address;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HMUL,
        S_DIVQ,
        S_DIVM,
        S_LKRD,
        S_LKCMP,
        S_LKMUL,
        S_ALPROBE,
        S_RLRD,
        S_RLCMP,
        S_RLOUT
    } state_t;

endpackage

/* rtl/inverted_page_table_hashed_unit.sv */
// Top level: hashed inverted page table with linear probing and a shared divider.
// Hash: run on the shared restoring divider, redone for each page. One request at a time.
// Lookup reads then compares each probed frame, plus an address step on a hit; allocate probes
// frames for each page in turn; release reads then compares every table entry, then reports.
// Results are registered onto strobe, the last as busy drops; the receiver cannot stall.
// Reset clears every valid mark and loads frame size 256, 64 frames in use, no reserved frames.
module inverted_page_table_hashed_unit
    import ipth_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 strobe,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FS_W-1:0]      cfg_data
);

    localparam int AW   = $clog2(NUM_FRAMES);
    localparam int NW   = $clog2(NUM_FRAMES + 1);
    localparam int XW   = PAGE_W + NW;
    localparam int DVW  = (XW > PID_W ? XW : PID_W) + 1;
    localparam int DCW  = $clog2(DVW);
    localparam int CW   = (NW > FIU_W ? NW : FIU_W);
    localparam int MW   = (AW > RES_W ? AW : RES_W) + 1;
    localparam int PW   = MW + FS_W;
    localparam int EW   = PID_W + PAGE_W;

    state_t              state_reg, state_next;
    logic [FS_W-1:0]     fs_reg;
    logic [FIU_W-1:0]    fiu_reg;
    logic [RES_W-1:0]    res_reg;
    cmd_t                cmd_reg, cmd_next;
    logic [PAGE_W-1:0]   page_cur_reg, page_cur_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [AW-1:0]       f_reg, f_next;
    logic [NW-1:0]       i_reg, i_next;
    logic                freed_reg, freed_next;
    logic [DVW-1:0]      quo_reg, quo_next;
    logic [FS_W-1:0]     rem_reg, rem_next;
    logic [FS_W-1:0]     dvs_reg, dvs_next;
    logic [DCW-1:0]      dcnt_reg, dcnt_next;
    logic                strobe_reg, strobe_next;
    result_t             result_reg, result_next;
    logic [NUM_FRAMES-1:0] valid_reg, valid_next;
    logic [EW-1:0]       mem [NUM_FRAMES];
    logic [EW-1:0]       mem_q;
    logic                mem_we;

    logic [FS_W-1:0]     fs_eff;
    logic [NW-1:0]       nf_eff;
    logic [CW-1:0]       fiu_x;
    logic [FS_W:0]       rem_sh;
    logic                sub_ok;
    logic [FS_W-1:0]     rem_step;
    logic [DVW-1:0]      quo_step;
    logic                div_done;
    logic                hit;
    logic                rel_match;
    logic                probe_last;
    logic [AW-1:0]       f_wrap;
    logic [NW:0]         f_inc;
    logic [CNT_W-1:0]    count_cap;
    logic [PW-1:0]       addr_full;

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        fs_eff = (fs_reg == '0) ? FS_W'(1) : fs_reg;
        fiu_x  = CW'(fiu_reg);
        if (fiu_reg == '0)
            nf_eff = NW'(1);
        else if (fiu_x > CW'(NUM_FRAMES))
            nf_eff = NW'(NUM_FRAMES);
        else
            nf_eff = NW'(fiu_x);
    end

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVW-1]};
        sub_ok   = (rem_sh >= {1'b0, dvs_reg});
        rem_step = sub_ok ? FS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[FS_W-1:0];
        quo_step = {quo_reg[DVW-2:0], sub_ok};
        div_done = (dcnt_reg == DCW'(DVW - 1));
    end

    always_comb
    begin
        hit        = valid_reg[f_reg] && (mem_q == {cmd_reg.pid, cmd_reg.page});
        rel_match  = valid_reg[f_reg] && (mem_q[EW-1:PAGE_W] == cmd_reg.pid) &&
                     ((cmd_reg.func == FUNC_REL_PID) || (mem_q[PAGE_W-1:0] == cmd_reg.page));
        probe_last = (i_reg == nf_eff - NW'(1));
        f_inc      = (NW + 1)'(f_reg) + (NW + 1)'(1);
        f_wrap     = (f_inc >= (NW + 1)'(nf_eff)) ? '0 : AW'(f_inc);
        count_cap  = (cmd.page_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cmd.page_count;
        addr_full  = ((PW'(f_reg) + PW'(res_reg)) * PW'(fs_eff)) + PW'(cmd_reg.offset);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == FUNC_REL_PID || cmd.func == FUNC_REL_PAGE)
                        state_next = S_RLRD;
                    else if (cmd.func == FUNC_ALLOC && count_cap == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_HMUL;
                end
            end
            S_HMUL:  state_next = S_DIVQ;
            S_DIVQ:  if (div_done) state_next = S_DIVM;
            S_DIVM:
            begin
                if (div_done)
                    state_next = (cmd_reg.func == FUNC_LOOKUP) ? S_LKRD : S_ALPROBE;
            end
            S_LKRD:  state_next = S_LKCMP;
            S_LKCMP:
            begin
                if (hit)
                    state_next = S_LKMUL;
                else if (probe_last)
                    state_next = S_IDLE;
                else
                    state_next = S_LKRD;
            end
            S_LKMUL: state_next = S_IDLE;
            S_ALPROBE:
            begin
                if (!valid_reg[f_reg])
                    state_next = (page_cur_reg + PAGE_W'(1) == PAGE_W'(count_reg)) ?
                                 S_IDLE : S_HMUL;
                else if (probe_last)
                    state_next = S_IDLE;
            end
            S_RLRD:  state_next = S_RLCMP;
            S_RLCMP: state_next = (f_reg == AW'(NUM_FRAMES - 1)) ? S_RLOUT : S_RLRD;
            S_RLOUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        page_cur_next = page_cur_reg;
        count_next    = count_reg;
        f_next        = f_reg;
        i_next        = i_reg;
        freed_next    = freed_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dvs_next      = dvs_reg;
        dcnt_next     = dcnt_reg;
        valid_next    = valid_reg;
        mem_we        = 1'b0;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    count_next    = count_cap;
                    page_cur_next = (cmd.func == FUNC_ALLOC) ? '0 : cmd.page;
                    f_next        = '0;
                    freed_next    = 1'b0;
                end
            end
            S_HMUL:
            begin
                quo_next  = DVW'(page_cur_reg) * DVW'(nf_eff);
                rem_next  = '0;
                dvs_next  = fs_eff;
                dcnt_next = '0;
            end
            S_DIVQ:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DCW'(1);
                if (div_done)
                begin
                    quo_next  = DVW'(cmd_reg.pid) + quo_step;
                    rem_next  = '0;
                    dvs_next  = FS_W'(nf_eff);
                    dcnt_next = '0;
                end
            end
            S_DIVM:
            begin
                quo_next  = quo_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg + DCW'(1);
                if (div_done)
                begin
                    f_next = AW'(rem_step);
                    i_next = '0;
                end
            end
            S_LKCMP:
            begin
                if (!hit)
                begin
                    i_next = i_reg + NW'(1);
                    f_next = f_wrap;
                    if (probe_last)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{status: ST_NOTFOUND, frame: '0,
                                        result_page: cmd_reg.page, address: '0, last: 1'b1};
                    end
                end
            end
            S_LKMUL:
            begin
                strobe_next = 1'b1;
                result_next = '{status: ST_OK, frame: FRAME_W'(f_reg),
                                result_page: cmd_reg.page, address: ADDR_W'(addr_full),
                                last: 1'b1};
            end
            S_ALPROBE:
            begin
                if (!valid_reg[f_reg])
                begin
                    valid_next[f_reg] = 1'b1;
                    mem_we            = 1'b1;
                    strobe_next       = 1'b1;
                    result_next       = '{status: ST_OK, frame: FRAME_W'(f_reg),
                                          result_page: page_cur_reg, address: '0,
                                          last: (page_cur_reg + PAGE_W'(1) ==
                                                 PAGE_W'(count_reg))};
                    page_cur_next     = page_cur_reg + PAGE_W'(1);
                end
                else
                begin
                    i_next = i_reg + NW'(1);
                    f_next = f_wrap;
                    if (probe_last)
                    begin
                        strobe_next = 1'b1;
                        result_next = '{status: ST_NOFREE, frame: '0,
                                        result_page: page_cur_reg, address: '0, last: 1'b1};
                    end
                end
            end
            S_RLCMP:
            begin
                if (rel_match)
                begin
                    valid_next[f_reg] = 1'b0;
                    freed_next        = 1'b1;
                end
                f_next = f_reg + AW'(1);
            end
            S_RLOUT:
            begin
                strobe_next = 1'b1;
                result_next = '{status: freed_reg ? ST_OK : ST_NOTFOUND, frame: '0,
                                result_page: (cmd_reg.func == FUNC_REL_PAGE) ?
                                             cmd_reg.page : '0,
                                address: '0, last: 1'b1};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[f_reg] <= {cmd_reg.pid, page_cur_reg};
        mem_q <= mem[f_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            strobe_reg <= 1'b0;
            fs_reg     <= FS_W'(256);
            fiu_reg    <= FIU_W'(64);
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            strobe_reg <= strobe_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_SIZE: fs_reg  <= cfg_data;
                    CFG_FRAMES:     fiu_reg <= cfg_data[FIU_W-1:0];
                    CFG_RESERVED:   res_reg <= cfg_data[RES_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        page_cur_reg <= page_cur_next;
        count_reg    <= count_next;
        f_reg        <= f_next;
        i_reg        <= i_next;
        freed_reg    <= freed_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        dcnt_reg     <= dcnt_next;
        result_reg   <= result_next;
    end

endmodule
